### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL of the point transform block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

### rtl/core/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Types and constants shared by the point transform block.
// ----------------------------------------------------------------------------
package ppt_pkg;

   localparam int COORD_W  = 32;
   localparam int GAIN_W   = 64;
   localparam int PROD_W   = 64;
   localparam int SUM_W    = 66;
   localparam int MAG_W    = 64;
   localparam int IDX_W    = 3;
   localparam int DIV_STEPS = 32;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   typedef enum logic [IDX_W-1:0] {
      REG_MODE     = 3'd0,
      REG_X_GAINS  = 3'd1,
      REG_X_OFFSET = 3'd2,
      REG_Y_GAINS  = 3'd3,
      REG_Y_OFFSET = 3'd4,
      REG_W_GAINS  = 3'd5,
      REG_W_OFFSET = 3'd6
   } csr_index_type;

   typedef enum logic {
      MODE_LINEAR     = 1'b0,
      MODE_PROJECTIVE = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                    mode;
      logic signed [COORD_W-1:0]   a;
      logic signed [COORD_W-1:0]   b;
      logic signed [COORD_W-1:0]   c;
      logic signed [COORD_W-1:0]   d;
      logic signed [COORD_W-1:0]   e;
      logic signed [COORD_W-1:0]   f;
      logic signed [COORD_W-1:0]   g;
      logic signed [COORD_W-1:0]   h;
      logic signed [COORD_W-1:0]   i;
   } cfg_type;

   // One divider lane: partial remainder, unused dividend bits, quotient so far, sign and overflow flag.
   typedef struct packed {
      logic [MAG_W-1:0]     rem;
      logic [COORD_W-1:0]   dvd_lo;
      logic [COORD_W-1:0]   quo;
      logic                 neg;
      logic                 ovf;
   } div_lane_type;

   // Values that ride alongside the divider.
   typedef struct packed {
      mode_type                    mode;
      logic signed [COORD_W-1:0]   lin_x;
      logic signed [COORD_W-1:0]   lin_y;
      logic                        lin_sat;
   } side_type;

endpackage

### rtl/core/projective_point_transform.sv
// ----------------------------------------------------------------------------
// projective_point_transform
// Linear or projective transform of one signed Q16.16 point per clock.
// ----------------------------------------------------------------------------
// The block takes one point in every clock cycle outside reset and delivers
// each result in order, on a one-cycle strobe that the receiver cannot hold
// off. After four front stages (products, row sums, magnitudes, divider
// set-up) the quotient is formed one bit per stage over 32 stages, and one
// final stage applies sign and saturation, or takes the clamped linear sums
// in linear mode. Busy is high only during reset. Configuration registers
// may only be written while no point is in flight; the pipeline reads the
// gains and mode in the products stage and the offsets in the row-sum stage.

`include "assert_macros.svh"

module projective_point_transform #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [ppt_pkg::COORD_W-1:0]   req_x_in,
   input  logic signed [ppt_pkg::COORD_W-1:0]   req_y_in,
   output logic                                 rsp_valid,
   output logic signed [ppt_pkg::COORD_W-1:0]   rsp_x_out,
   output logic signed [ppt_pkg::COORD_W-1:0]   rsp_y_out,
   output logic                                 rsp_saturated,
   input  logic                                 csr_we,
   input  logic [ppt_pkg::IDX_W-1:0]            csr_index,
   input  logic [ppt_pkg::GAIN_W-1:0]           csr_wdata
);

   localparam int STEPS   = ppt_pkg::DIV_STEPS;
   localparam int LATENCY = 4 + STEPS + 1;

   ppt_pkg::cfg_type cfg;
   logic             accept;

   // Nothing is taken while reset clears the pipeline.
   assign busy   = reset;
   assign accept = start & ~busy;

   ppt_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Divider pipeline: entry 0 is the front end output, entry k the output
   // of division step k.
   logic                       dv_valid   [0:STEPS];
   ppt_pkg::div_lane_type      dv_x       [0:STEPS];
   ppt_pkg::div_lane_type      dv_y       [0:STEPS];
   logic [ppt_pkg::MAG_W-1:0]  dv_divisor [0:STEPS];
   ppt_pkg::side_type          dv_side    [0:STEPS];

   ppt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .x_in      (req_x_in),
      .y_in      (req_y_in),
      .cfg       (cfg),
      .out_valid (dv_valid[0]),
      .lane_x    (dv_x[0]),
      .lane_y    (dv_y[0]),
      .divisor   (dv_divisor[0]),
      .side      (dv_side[0])
   );

   for (genvar k = 0; k < STEPS; k++) begin : g_div
      ppt_div_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (dv_valid[k]),
         .in_x        (dv_x[k]),
         .in_y        (dv_y[k]),
         .in_divisor  (dv_divisor[k]),
         .in_side     (dv_side[k]),
         .out_valid   (dv_valid[k+1]),
         .out_x       (dv_x[k+1]),
         .out_y       (dv_y[k+1]),
         .out_divisor (dv_divisor[k+1]),
         .out_side    (dv_side[k+1])
      );
   end

   // Output stage: apply the sign to each quotient and clip it. A negative
   // result may reach one step further than a positive one.
   logic                              rsp_valid_ff;
   logic signed [ppt_pkg::COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                              rsp_sat_ff, rsp_sat_in;
   logic                              sat_x, sat_y;

   always_comb begin
      ppt_pkg::div_lane_type lx;
      ppt_pkg::div_lane_type ly;
      lx = dv_x[STEPS];
      ly = dv_y[STEPS];

      sat_x = lx.ovf
              || (!lx.neg && lx.quo > ppt_pkg::COORD_W'(ppt_pkg::COORD_MAX))
              || (lx.neg && lx.quo > ppt_pkg::COORD_W'(ppt_pkg::COORD_MIN));
      if (sat_x) begin
         rsp_x_in = lx.neg ? ppt_pkg::COORD_MIN : ppt_pkg::COORD_MAX;
      end else begin
         rsp_x_in = lx.neg ? -lx.quo : lx.quo;
      end

      sat_y = ly.ovf
              || (!ly.neg && ly.quo > ppt_pkg::COORD_W'(ppt_pkg::COORD_MAX))
              || (ly.neg && ly.quo > ppt_pkg::COORD_W'(ppt_pkg::COORD_MIN));
      if (sat_y) begin
         rsp_y_in = ly.neg ? ppt_pkg::COORD_MIN : ppt_pkg::COORD_MAX;
      end else begin
         rsp_y_in = ly.neg ? -ly.quo : ly.quo;
      end

      rsp_sat_in = sat_x | sat_y;

      // In linear mode the clamped sums from the front end are used instead.
      if (dv_side[STEPS].mode == ppt_pkg::MODE_LINEAR) begin
         rsp_x_in   = dv_side[STEPS].lin_x;
         rsp_y_in   = dv_side[STEPS].lin_y;
         rsp_sat_in = dv_side[STEPS].lin_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid[STEPS];
      end
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_x_out     = rsp_x_ff;
   assign rsp_y_out     = rsp_y_ff;
   assign rsp_saturated = rsp_sat_ff;

   // Every result comes from an item that was accepted.
   `ASSERT_IMPLIES(a_result_has_item, clock, reset, rsp_valid, $past(accept, LATENCY))

   // A saturated result holds at least one coordinate at a range limit.
   `ASSERT_IMPLIES(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated,
      rsp_x_out == ppt_pkg::COORD_MAX || rsp_x_out == ppt_pkg::COORD_MIN ||
      rsp_y_out == ppt_pkg::COORD_MAX || rsp_y_out == ppt_pkg::COORD_MIN)

   // The small-w fix-up never lets a divisor below one LSB into the divider.
   `ASSERT_NEVER(a_divisor_floor, clock, reset,
      dv_valid[0] && (dv_divisor[0] >> FRAC_BITS) == '0)

endmodule

### rtl/core/ppt_csr.sv
// ----------------------------------------------------------------------------
// ppt_csr
// Configuration registers of the point transform block.
// ----------------------------------------------------------------------------
module ppt_csr #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [ppt_pkg::IDX_W-1:0]    csr_index,
   input  logic [ppt_pkg::GAIN_W-1:0]   csr_wdata,
   output ppt_pkg::cfg_type             cfg
);

   localparam logic signed [ppt_pkg::COORD_W-1:0] ONE =
      ppt_pkg::COORD_W'(1) << FRAC_BITS;

   ppt_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (ppt_pkg::csr_index_type'(csr_index))
            ppt_pkg::REG_MODE: begin
               cfg_in.mode = ppt_pkg::mode_type'(csr_wdata[0]);
            end
            ppt_pkg::REG_X_GAINS: begin
               cfg_in.a = csr_wdata[63:32];
               cfg_in.b = csr_wdata[31:0];
            end
            ppt_pkg::REG_X_OFFSET: begin
               cfg_in.c = csr_wdata[31:0];
            end
            ppt_pkg::REG_Y_GAINS: begin
               cfg_in.d = csr_wdata[63:32];
               cfg_in.e = csr_wdata[31:0];
            end
            ppt_pkg::REG_Y_OFFSET: begin
               cfg_in.f = csr_wdata[31:0];
            end
            ppt_pkg::REG_W_GAINS: begin
               cfg_in.g = csr_wdata[63:32];
               cfg_in.h = csr_wdata[31:0];
            end
            ppt_pkg::REG_W_OFFSET: begin
               cfg_in.i = csr_wdata[31:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= ppt_pkg::MODE_LINEAR;
         cfg_ff.a    <= ONE;
         cfg_ff.b    <= '0;
         cfg_ff.c    <= '0;
         cfg_ff.d    <= '0;
         cfg_ff.e    <= ONE;
         cfg_ff.f    <= '0;
         cfg_ff.g    <= '0;
         cfg_ff.h    <= '0;
         cfg_ff.i    <= ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/ppt_front.sv
// ----------------------------------------------------------------------------
// ppt_front
// Front stages: products, row sums, magnitudes and divider set-up.
// ----------------------------------------------------------------------------
module ppt_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [ppt_pkg::COORD_W-1:0]   x_in,
   input  logic signed [ppt_pkg::COORD_W-1:0]   y_in,
   input  ppt_pkg::cfg_type                     cfg,
   output logic                                 out_valid,
   output ppt_pkg::div_lane_type                lane_x,
   output ppt_pkg::div_lane_type                lane_y,
   output logic [ppt_pkg::MAG_W-1:0]            divisor,
   output ppt_pkg::side_type                    side
);

   localparam int PROD_W = ppt_pkg::PROD_W;
   localparam int SUM_W  = ppt_pkg::SUM_W;
   localparam int MAG_W  = ppt_pkg::MAG_W;
   localparam int LIN_W  = PROD_W + 1 - FRAC_BITS;
   localparam int WIDE_W = MAG_W + ppt_pkg::COORD_W;
   localparam logic signed [LIN_W-1:0] LIN_MAX = LIN_W'(ppt_pkg::COORD_MAX);
   localparam logic signed [LIN_W-1:0] LIN_MIN = LIN_W'(ppt_pkg::COORD_MIN);
   localparam logic [MAG_W-1:0] W_LSB = MAG_W'(1) << FRAC_BITS;

   // Stage A: the six products.
   logic                       a_valid_ff;
   ppt_pkg::mode_type          a_mode_ff;
   logic signed [PROD_W-1:0]   pax_ff, pby_ff, pdx_ff, pey_ff, pgx_ff, phy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_mode_ff <= cfg.mode;
      pax_ff    <= PROD_W'(cfg.a) * PROD_W'(x_in);
      pby_ff    <= PROD_W'(cfg.b) * PROD_W'(y_in);
      pdx_ff    <= PROD_W'(cfg.d) * PROD_W'(x_in);
      pey_ff    <= PROD_W'(cfg.e) * PROD_W'(y_in);
      pgx_ff    <= PROD_W'(cfg.g) * PROD_W'(x_in);
      phy_ff    <= PROD_W'(cfg.h) * PROD_W'(y_in);
   end

   // Stage B: exact row sums and the floored linear sums.
   logic                       b_valid_ff;
   ppt_pkg::mode_type          b_mode_ff;
   logic signed [SUM_W-1:0]    sx_ff, sy_ff, sw_ff;
   logic signed [LIN_W-1:0]    lx_ff, ly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_mode_ff <= a_mode_ff;
      sx_ff <= SUM_W'(pax_ff) + SUM_W'(pby_ff) + (SUM_W'(cfg.c) <<< FRAC_BITS);
      sy_ff <= SUM_W'(pdx_ff) + SUM_W'(pey_ff) + (SUM_W'(cfg.f) <<< FRAC_BITS);
      sw_ff <= SUM_W'(pgx_ff) + SUM_W'(phy_ff) + (SUM_W'(cfg.i) <<< FRAC_BITS);
      lx_ff <= LIN_W'(pax_ff >>> FRAC_BITS) + LIN_W'(pby_ff >>> FRAC_BITS);
      ly_ff <= LIN_W'(pdx_ff >>> FRAC_BITS) + LIN_W'(pey_ff >>> FRAC_BITS);
   end

   // Stage C: sign and magnitude, small-w fix-up, linear clamp.
   logic                       c_valid_ff;
   ppt_pkg::side_type          c_side_ff, c_side_in;
   logic [MAG_W-1:0]           mx_ff, my_ff, mw_ff, mw_in;
   logic                       nx_ff, ny_ff, nw_ff, nw_in;
   logic                       lsx, lsy;

   always_comb begin
      mw_in = sw_ff[SUM_W-1] ? MAG_W'(-sw_ff) : MAG_W'(sw_ff);
      nw_in = sw_ff[SUM_W-1];
      if (mw_in < W_LSB) begin
         if (mw_in == '0) begin
            nw_in = 1'b0;
         end
         mw_in = W_LSB;
      end

      c_side_in.mode = b_mode_ff;
      lsx = 1'b1;
      lsy = 1'b1;
      if (lx_ff > LIN_MAX) begin
         c_side_in.lin_x = ppt_pkg::COORD_MAX;
      end else if (lx_ff < LIN_MIN) begin
         c_side_in.lin_x = ppt_pkg::COORD_MIN;
      end else begin
         c_side_in.lin_x = lx_ff[ppt_pkg::COORD_W-1:0];
         lsx = 1'b0;
      end
      if (ly_ff > LIN_MAX) begin
         c_side_in.lin_y = ppt_pkg::COORD_MAX;
      end else if (ly_ff < LIN_MIN) begin
         c_side_in.lin_y = ppt_pkg::COORD_MIN;
      end else begin
         c_side_in.lin_y = ly_ff[ppt_pkg::COORD_W-1:0];
         lsy = 1'b0;
      end
      c_side_in.lin_sat = lsx | lsy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_side_ff <= c_side_in;
      nx_ff <= sx_ff[SUM_W-1];
      ny_ff <= sy_ff[SUM_W-1];
      mx_ff <= sx_ff[SUM_W-1] ? MAG_W'(-sx_ff) : MAG_W'(sx_ff);
      my_ff <= sy_ff[SUM_W-1] ? MAG_W'(-sy_ff) : MAG_W'(sy_ff);
      mw_ff <= mw_in;
      nw_ff <= nw_in;
   end

   // Stage D: overflow test and the first partial remainder of each lane.
   logic                       d_valid_ff;
   ppt_pkg::side_type          d_side_ff;
   ppt_pkg::div_lane_type      d_lx_ff, d_ly_ff, d_lx_in, d_ly_in;
   logic [MAG_W-1:0]           d_mw_ff;
   logic [WIDE_W-1:0]          w_limit;

   always_comb begin
      // The quotient fits 32 bits exactly when mag * 2^F < w * 2^32.
      w_limit = WIDE_W'(mw_ff) << (ppt_pkg::COORD_W - FRAC_BITS);

      d_lx_in.rem    = mx_ff >> (ppt_pkg::COORD_W - FRAC_BITS);
      d_lx_in.dvd_lo = ppt_pkg::COORD_W'(mx_ff << FRAC_BITS);
      d_lx_in.quo    = '0;
      d_lx_in.neg    = nx_ff ^ nw_ff;
      d_lx_in.ovf    = WIDE_W'(mx_ff) >= w_limit;

      d_ly_in.rem    = my_ff >> (ppt_pkg::COORD_W - FRAC_BITS);
      d_ly_in.dvd_lo = ppt_pkg::COORD_W'(my_ff << FRAC_BITS);
      d_ly_in.quo    = '0;
      d_ly_in.neg    = ny_ff ^ nw_ff;
      d_ly_in.ovf    = WIDE_W'(my_ff) >= w_limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
      d_side_ff <= c_side_ff;
      d_lx_ff   <= d_lx_in;
      d_ly_ff   <= d_ly_in;
      d_mw_ff   <= mw_ff;
   end

   assign out_valid = d_valid_ff;
   assign lane_x    = d_lx_ff;
   assign lane_y    = d_ly_ff;
   assign divisor   = d_mw_ff;
   assign side      = d_side_ff;

endmodule

### rtl/core/ppt_div_stage.sv
// ----------------------------------------------------------------------------
// ppt_div_stage
// One restoring division step for the x and y lanes, registered.
// ----------------------------------------------------------------------------
module ppt_div_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  ppt_pkg::div_lane_type          in_x,
   input  ppt_pkg::div_lane_type          in_y,
   input  logic [ppt_pkg::MAG_W-1:0]      in_divisor,
   input  ppt_pkg::side_type              in_side,
   output logic                           out_valid,
   output ppt_pkg::div_lane_type          out_x,
   output ppt_pkg::div_lane_type          out_y,
   output logic [ppt_pkg::MAG_W-1:0]      out_divisor,
   output ppt_pkg::side_type              out_side
);

   function automatic ppt_pkg::div_lane_type step(
      input ppt_pkg::div_lane_type   lane,
      input logic [ppt_pkg::MAG_W-1:0] dv
   );
      logic [ppt_pkg::MAG_W:0]  trial;
      logic                     ge;
      ppt_pkg::div_lane_type    res;
      trial      = {lane.rem, lane.dvd_lo[ppt_pkg::COORD_W-1]};
      ge         = trial >= {1'b0, dv};
      res        = lane;
      res.rem    = ge ? ppt_pkg::MAG_W'(trial - {1'b0, dv})
                      : trial[ppt_pkg::MAG_W-1:0];
      res.dvd_lo = lane.dvd_lo << 1;
      res.quo    = {lane.quo[ppt_pkg::COORD_W-2:0], ge};
      return res;
   endfunction

   logic                       valid_ff;
   ppt_pkg::div_lane_type      x_ff, y_ff;
   logic [ppt_pkg::MAG_W-1:0]  divisor_ff;
   ppt_pkg::side_type          side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      x_ff       <= step(in_x, in_divisor);
      y_ff       <= step(in_y, in_divisor);
      divisor_ff <= in_divisor;
      side_ff    <= in_side;
   end

   assign out_valid   = valid_ff;
   assign out_x       = x_ff;
   assign out_y       = y_ff;
   assign out_divisor = divisor_ff;
   assign out_side    = side_ff;

endmodule

### tb/sv/projective_point_transform_tb.sv
// ----------------------------------------------------------------------------
// projective_point_transform_tb
// Self-checking bench for the linear and projective point transform.
// ----------------------------------------------------------------------------
// Points are sent on the start/busy command port and every result strobe is
// compared with a typed row or a software transform mirror, which keeps its own
// copy of the nine coefficients and the mode. A short directed table covers
// the reset identity, overflow in both modes, zero and tiny w and extreme
// coefficients. Random phases with random coefficient sets follow.
// ----------------------------------------------------------------------------

module projective_point_transform_tb;

   // Pipeline depth of the block; the settle wait adds a margin on top.
   localparam int PIPE_DEPTH   = 37;
   localparam int SETTLE_WAIT  = PIPE_DEPTH + 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int RAND_PHASES  = 6;
   localparam int PHASE_POINTS = 125;
   localparam int DIR_ROWS     = 19;
   localparam int FRAC_Q       = 16;
   localparam logic [ppt_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam logic signed [ppt_pkg::COORD_W-1:0] ONE_Q16 = 32'sh0001_0000;

   typedef struct {
      logic signed [ppt_pkg::COORD_W-1:0] x;
      logic signed [ppt_pkg::COORD_W-1:0] y;
      logic                               sat;
   } point_res_type;

   typedef struct {
      int                                 set;
      logic signed [ppt_pkg::COORD_W-1:0] x;
      logic signed [ppt_pkg::COORD_W-1:0] y;
      bit                                 typed;
      point_res_type                      res;
   } dir_row_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic signed [ppt_pkg::COORD_W-1:0]   req_x_in;
   logic signed [ppt_pkg::COORD_W-1:0]   req_y_in;
   logic                                 rsp_valid;
   logic signed [ppt_pkg::COORD_W-1:0]   rsp_x_out;
   logic signed [ppt_pkg::COORD_W-1:0]   rsp_y_out;
   logic                                 rsp_saturated;
   logic                                 csr_we;
   logic [ppt_pkg::IDX_W-1:0]            csr_index;
   logic [ppt_pkg::GAIN_W-1:0]           csr_wdata;

   projective_point_transform u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_x_in      (req_x_in),
      .req_y_in      (req_y_in),
      .rsp_valid     (rsp_valid),
      .rsp_x_out     (rsp_x_out),
      .rsp_y_out     (rsp_y_out),
      .rsp_saturated (rsp_saturated),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Mirror of the coefficient registers as the block should hold them.
   ppt_pkg::cfg_type coef_q;
   point_res_type    pending_points [$];
   bit               fail_seen;
   int               stall_count;

   // Expectation typed into the directed table for the item being driven.
   bit               next_typed;
   point_res_type    next_res;

   always begin
      #4 clock = ~clock;
   end

   function automatic ppt_pkg::cfg_type reset_coefs();
      ppt_pkg::cfg_type c;
      c      = '0;
      c.mode = ppt_pkg::MODE_LINEAR;
      c.a    = ONE_Q16;
      c.e    = ONE_Q16;
      c.i    = ONE_Q16;
      return c;
   endfunction

   // Clips a wide value to the 32-bit coordinate range and flags the clip.
   function automatic logic signed [ppt_pkg::COORD_W-1:0] clip_coord(
      input logic signed [ppt_pkg::SUM_W-1:0] v, inout logic sat);
      if (v > ppt_pkg::COORD_MAX) begin
         sat = 1'b1;
         return ppt_pkg::COORD_MAX;
      end
      if (v < ppt_pkg::COORD_MIN) begin
         sat = 1'b1;
         return ppt_pkg::COORD_MIN;
      end
      return v[ppt_pkg::COORD_W-1:0];
   endfunction

   // Exact p*x + q*y + k at 32 fractional bits, held in 66 bits.
   function automatic logic signed [ppt_pkg::SUM_W-1:0] row_sum(
      input logic signed [ppt_pkg::COORD_W-1:0] p, q, k, x, y);
      logic signed [ppt_pkg::SUM_W-1:0] px, qy, ks;
      px = p * x;
      qy = q * y;
      ks = k;
      ks = ks <<< FRAC_Q;
      return px + qy + ks;
   endfunction

   // Quotient of |n| * 2^16 / |w|, truncated toward zero, then signed and clipped.
   function automatic logic signed [ppt_pkg::COORD_W-1:0] scaled_quotient(
      input logic [ppt_pkg::MAG_W-1:0] n_mag, input bit neg,
      input logic [ppt_pkg::MAG_W-1:0] w_mag, inout logic sat);
      logic [127:0] num, quo;
      num = {48'b0, n_mag, 16'b0};
      quo = num / {64'b0, w_mag};
      if (!neg) begin
         if (quo > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return ppt_pkg::COORD_MAX;
         end
         return quo[ppt_pkg::COORD_W-1:0];
      end
      if (quo > 128'h8000_0000) begin
         sat = 1'b1;
         return ppt_pkg::COORD_MIN;
      end
      return -quo[ppt_pkg::COORD_W-1:0];
   endfunction

   function automatic point_res_type transform_point(
      input ppt_pkg::cfg_type c, input logic signed [ppt_pkg::COORD_W-1:0] x, y);
      point_res_type                     r;
      logic signed [ppt_pkg::PROD_W-1:0] pa, pb, pd, pe;
      logic signed [ppt_pkg::SUM_W-1:0]  sx, sy, sw;
      logic [ppt_pkg::MAG_W-1:0]         mx, my, mw;
      bit                                wneg;
      r.sat = 1'b0;
      if (c.mode == ppt_pkg::MODE_LINEAR) begin
         // Each product is floored to Q16.16 before the two are added.
         pa = c.a * x;
         pb = c.b * y;
         pd = c.d * x;
         pe = c.e * y;
         sx = (ppt_pkg::SUM_W'(pa) >>> FRAC_Q) + (ppt_pkg::SUM_W'(pb) >>> FRAC_Q);
         sy = (ppt_pkg::SUM_W'(pd) >>> FRAC_Q) + (ppt_pkg::SUM_W'(pe) >>> FRAC_Q);
         r.x = clip_coord(sx, r.sat);
         r.y = clip_coord(sy, r.sat);
      end else begin
         sx = row_sum(c.a, c.b, c.c, x, y);
         sy = row_sum(c.d, c.e, c.f, x, y);
         sw = row_sum(c.g, c.h, c.i, x, y);
         mx = (sx < 0) ? ppt_pkg::MAG_W'(-sx) : ppt_pkg::MAG_W'(sx);
         my = (sy < 0) ? ppt_pkg::MAG_W'(-sy) : ppt_pkg::MAG_W'(sy);
         mw = (sw < 0) ? ppt_pkg::MAG_W'(-sw) : ppt_pkg::MAG_W'(sw);
         wneg = sw < 0;
         // A w below one LSB becomes one LSB; a zero w counts as positive.
         if (mw < (64'd1 << FRAC_Q)) begin
            if (mw == 0) wneg = 1'b0;
            mw = 64'd1 << FRAC_Q;
         end
         r.x = scaled_quotient(mx, (sx < 0) != wneg, mw, r.sat);
         r.y = scaled_quotient(my, (sy < 0) != wneg, mw, r.sat);
      end
      return r;
   endfunction

   // Register writes, item acceptance and result checking, all at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         coef_q = reset_coefs();
      end else begin
         if (csr_we) begin
            case (csr_index)
               ppt_pkg::REG_MODE:     coef_q.mode = ppt_pkg::mode_type'(csr_wdata[0]);
               ppt_pkg::REG_X_GAINS:  {coef_q.a, coef_q.b} = csr_wdata;
               ppt_pkg::REG_X_OFFSET: coef_q.c = csr_wdata[ppt_pkg::COORD_W-1:0];
               ppt_pkg::REG_Y_GAINS:  {coef_q.d, coef_q.e} = csr_wdata;
               ppt_pkg::REG_Y_OFFSET: coef_q.f = csr_wdata[ppt_pkg::COORD_W-1:0];
               ppt_pkg::REG_W_GAINS:  {coef_q.g, coef_q.h} = csr_wdata;
               ppt_pkg::REG_W_OFFSET: coef_q.i = csr_wdata[ppt_pkg::COORD_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (next_typed) pending_points.push_back(next_res);
            else pending_points.push_back(transform_point(coef_q, req_x_in, req_y_in));
         end
         if (rsp_valid) begin
            if (pending_points.size() == 0) begin
               $display("%0t: result with none expected: x %h y %h sat %b", $time,
                        rsp_x_out, rsp_y_out, rsp_saturated);
               fail_seen = 1'b1;
            end else begin
               point_res_type want;
               want = pending_points.pop_front();
               if (rsp_x_out !== want.x) begin
                  $display("%0t: x_out expected %h actual %h", $time, want.x, rsp_x_out);
                  fail_seen = 1'b1;
               end
               if (rsp_y_out !== want.y) begin
                  $display("%0t: y_out expected %h actual %h", $time, want.y, rsp_y_out);
                  fail_seen = 1'b1;
               end
               if (rsp_saturated !== want.sat) begin
                  $display("%0t: saturated expected %b actual %b", $time, want.sat,
                           rsp_saturated);
                  fail_seen = 1'b1;
               end
            end
         end
      end
   end

   // The watchdog counts cycles in which neither side moves an item.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_point(input logic signed [ppt_pkg::COORD_W-1:0] x, y,
                             input bit typed, input point_res_type res);
      @(negedge clock);
      start      <= 1'b1;
      req_x_in   <= x;
      req_y_in   <= y;
      next_typed  = typed;
      next_res    = res;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Waits until every point in flight has come back, with a margin for the pipe.
   task automatic drain();
      idle_for(1);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ppt_pkg::IDX_W-1:0] idx,
                            input logic [ppt_pkg::GAIN_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Writes every register; the unused upper bits of the narrow ones get noise,
   // and a write to the unused index must leave everything alone.
   task automatic load_coefs(input ppt_pkg::cfg_type c);
      drain();
      write_reg(ppt_pkg::REG_MODE, {$urandom, 31'($urandom), c.mode});
      write_reg(ppt_pkg::REG_X_GAINS, {c.a, c.b});
      write_reg(ppt_pkg::REG_X_OFFSET, {$urandom, c.c});
      write_reg(ppt_pkg::REG_Y_GAINS, {c.d, c.e});
      write_reg(ppt_pkg::REG_Y_OFFSET, {$urandom, c.f});
      write_reg(ppt_pkg::REG_W_GAINS, {c.g, c.h});
      write_reg(ppt_pkg::REG_W_OFFSET, {$urandom, c.i});
      write_reg(REG_UNUSED, {$urandom, $urandom});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Coordinates: full range, near the origin, moderate, or an extreme value.
   function automatic logic signed [ppt_pkg::COORD_W-1:0] pick_value();
      logic signed [ppt_pkg::COORD_W-1:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 32'h0004_0000);
         2: v = $urandom_range(0, 32'h0100_0000);
         default: begin
            case ($urandom_range(0, 4))
               0: v = ppt_pkg::COORD_MAX;
               1: v = ppt_pkg::COORD_MIN;
               2: v = 0;
               3: v = 1;
               default: v = -1;
            endcase
         end
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   function automatic ppt_pkg::cfg_type random_coefs();
      ppt_pkg::cfg_type c;
      c.mode = ppt_pkg::mode_type'($urandom_range(0, 1));
      c.a = pick_value();
      c.b = pick_value();
      c.c = pick_value();
      c.d = pick_value();
      c.e = pick_value();
      c.f = pick_value();
      // Keep w near one most of the time so that the quotients stay in range.
      if ($urandom_range(0, 2) != 0) begin
         c.g = $signed($urandom_range(0, 2048)) - 1024;
         c.h = $signed($urandom_range(0, 2048)) - 1024;
         c.i = ONE_Q16 + $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
      end else begin
         c.g = pick_value();
         c.h = pick_value();
         c.i = pick_value();
      end
      return c;
   endfunction

   initial begin
      ppt_pkg::cfg_type dir_cfg [4];
      dir_row_type      dir_table [DIR_ROWS];
      point_res_type    none;
      int               cur_set;

      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_x_in    = '0;
      req_y_in    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      fail_seen   = 1'b0;
      stall_count = 0;
      next_typed  = 1'b0;
      none        = '{x: 0, y: 0, sat: 1'b0};
      next_res    = none;
      coef_q      = reset_coefs();

      // Set 0 is the state after reset, the identity.
      dir_cfg[0] = reset_coefs();
      // Set 1: linear with the largest gains, so that both outputs can overflow.
      dir_cfg[1] = '{mode: ppt_pkg::MODE_LINEAR, a: ppt_pkg::COORD_MAX,
                     b: ppt_pkg::COORD_MAX, c: 0, d: ppt_pkg::COORD_MIN,
                     e: ppt_pkg::COORD_MIN, f: 0, g: 0, h: 0, i: 0};
      // Set 2: w = x at one LSB per unit, giving zero and tiny w for small x.
      dir_cfg[2] = '{mode: ppt_pkg::MODE_PROJECTIVE, a: ONE_Q16, b: 0, c: 0, d: 0,
                     e: ONE_Q16, f: 0, g: 1, h: 0, i: 0};
      // Set 3: projective with every coefficient at an extreme.
      dir_cfg[3] = '{mode: ppt_pkg::MODE_PROJECTIVE, a: ppt_pkg::COORD_MIN,
                     b: ppt_pkg::COORD_MAX, c: ppt_pkg::COORD_MIN,
                     d: ppt_pkg::COORD_MAX, e: ppt_pkg::COORD_MIN,
                     f: ppt_pkg::COORD_MAX, g: ppt_pkg::COORD_MIN,
                     h: ppt_pkg::COORD_MIN, i: ppt_pkg::COORD_MAX};

      dir_table = '{
         '{0, 0, 0, 1, '{0, 0, 1'b0}},
         '{0, ppt_pkg::COORD_MAX, ppt_pkg::COORD_MIN, 1,
           '{ppt_pkg::COORD_MAX, ppt_pkg::COORD_MIN, 1'b0}},
         '{0, ppt_pkg::COORD_MIN, ppt_pkg::COORD_MAX, 1,
           '{ppt_pkg::COORD_MIN, ppt_pkg::COORD_MAX, 1'b0}},
         '{0, 1, -1, 1, '{1, -1, 1'b0}},
         '{0, ONE_Q16, -ONE_Q16, 1, '{ONE_Q16, -ONE_Q16, 1'b0}},
         '{1, ppt_pkg::COORD_MAX, ppt_pkg::COORD_MAX, 1,
           '{ppt_pkg::COORD_MAX, ppt_pkg::COORD_MIN, 1'b1}},
         '{1, 0, 0, 1, '{0, 0, 1'b0}},
         '{1, ppt_pkg::COORD_MIN, ppt_pkg::COORD_MIN, 0, none},
         '{1, ppt_pkg::COORD_MAX, ppt_pkg::COORD_MIN, 0, none},
         '{1, 1, 1, 0, none},
         '{2, 0, 0, 0, none},
         '{2, 1, 7, 0, none},
         '{2, -1, 7, 0, none},
         '{2, ppt_pkg::COORD_MAX, 5, 0, none},
         '{2, ppt_pkg::COORD_MIN, ppt_pkg::COORD_MIN, 0, none},
         '{3, ppt_pkg::COORD_MAX, ppt_pkg::COORD_MAX, 0, none},
         '{3, ppt_pkg::COORD_MIN, ppt_pkg::COORD_MIN, 0, none},
         '{3, 0, 0, 0, none},
         '{3, 12345, -9876, 0, none}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: a new coefficient set is loaded whenever the row asks.
      cur_set = 0;
      foreach (dir_table[n]) begin
         if (dir_table[n].set != cur_set) begin
            cur_set = dir_table[n].set;
            load_coefs(dir_cfg[cur_set]);
         end
         send_point(dir_table[n].x, dir_table[n].y, dir_table[n].typed, dir_table[n].res);
      end

      // Random phases, each under its own coefficient set. The last one runs
      // back to back with no gaps on the input side.
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         load_coefs(random_coefs());
         for (int k = 0; k < PHASE_POINTS; k++) begin
            if (ph != RAND_PHASES - 1 && $urandom_range(0, 4) == 0)
               idle_for($urandom_range(1, 19));
            send_point(pick_value(), pick_value(), 1'b0, none);
         end
      end

      drain();
      if (!fail_seen) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
